// ===== design/bitmap_font_stream_decoder_top_defines.svh =====
// Assertion macros used by the font stream decoder top module.
`ifndef BITMAP_FONT_STREAM_DECODER_TOP_DEFINES_SVH
`define BITMAP_FONT_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bfsd_pkg.sv =====
// Types, codes and constants of the bitmap font stream decoder.
package bfsd_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_GLYPH   = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_IGNORED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_MAGIC       = 3'd1,
        ERR_VERSION     = 3'd2,
        ERR_ZERO_WIDTH  = 3'd3,
        ERR_ZERO_HEIGHT = 3'd4,
        ERR_ZERO_COUNT  = 3'd5,
        ERR_TRUNCATED   = 3'd6
    } err_t;

    // Header byte positions; POS_DATA marks the glyph data phase.
    localparam logic [3:0] POS_MAGIC0   = 4'd0;
    localparam logic [3:0] POS_VERSION0 = 4'd3;
    localparam logic [3:0] POS_VERSION2 = 4'd5;
    localparam logic [3:0] POS_WIDTH    = 4'd6;
    localparam logic [3:0] POS_HEIGHT   = 4'd7;
    localparam logic [3:0] POS_COUNT_HI = 4'd8;
    localparam logic [3:0] POS_COUNT_LO = 4'd9;
    localparam logic [3:0] POS_DATA     = 4'd10;

    localparam logic [7:0] FULL_MASK  = 8'hFF;
    localparam logic [3:0] FULL_COUNT = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        err_t        error_code;
        logic [15:0] glyph_number;
        logic [12:0] byte_offset;
        logic [7:0]  pixels;
        logic [3:0]  pixel_count;
        logic        glyph_end;
        logic        font_end;
        logic [7:0]  cell_width;
        logic [7:0]  cell_height;
        logic [15:0] glyph_total;
    } result_t;

    // Expected text of the first six header bytes: "BMP" then "000".
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h42;
            3'd1:    ch = 8'h4D;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h30;
            3'd4:    ch = 8'h30;
            3'd5:    ch = 8'h30;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/bitmap_font_stream_decoder_top.sv =====
// An accepted item passes through the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while out_ready stays high; each byte is decoded in a single pass of the core logic.
// While a result waits, the input register still takes one more item, then in_ready drops.
// Reset (rst_n low, asynchronous) clears both stages, the header position, the stored
// header values, the glyph counters, the held error and the finished flag.
module bitmap_font_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [2:0]  error_code,
    output logic [15:0] glyph_number,
    output logic [12:0] byte_offset,
    output logic [7:0]  pixels,
    output logic [3:0]  pixel_count,
    output logic        glyph_end,
    output logic        font_end,
    output logic [7:0]  cell_width,
    output logic [7:0]  cell_height,
    output logic [15:0] glyph_total
);

    `include "bitmap_font_stream_decoder_top_defines.svh"

    bfsd_pkg::in_item_t in_item;
    bfsd_pkg::in_item_t held_item;
    bfsd_pkg::result_t  core_result;
    bfsd_pkg::result_t  out_result;
    logic               held_valid;
    logic               out_space;
    logic               advance;

    assign in_item.data_byte = data_byte;
    assign in_item.is_last   = is_last;
    assign advance           = held_valid && out_space;

    bfsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (in_item),
        .pop        (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    bfsd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .item   (held_item),
        .result (core_result)
    );

    bfsd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (core_result),
        .space      (out_space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    assign kind         = out_result.kind;
    assign error_code   = out_result.error_code;
    assign glyph_number = out_result.glyph_number;
    assign byte_offset  = out_result.byte_offset;
    assign pixels       = out_result.pixels;
    assign pixel_count  = out_result.pixel_count;
    assign glyph_end    = out_result.glyph_end;
    assign font_end     = out_result.font_end;
    assign cell_width   = out_result.cell_width;
    assign cell_height  = out_result.cell_height;
    assign glyph_total  = out_result.glyph_total;

    `BFSD_ASSERT_NOW(a_err_code_only_on_error, clk, rst_n,
        out_valid, ((kind == bfsd_pkg::KIND_ERROR) == (error_code != bfsd_pkg::ERR_NONE)),
        "error code does not match result kind")

    `BFSD_ASSERT_NOW(a_glyph_pixel_count, clk, rst_n,
        out_valid && kind == bfsd_pkg::KIND_GLYPH,
        pixel_count >= 4'd1 && pixel_count <= bfsd_pkg::FULL_COUNT
            && (glyph_end || pixel_count == bfsd_pkg::FULL_COUNT)
            && (!font_end || glyph_end),
        "glyph data item has an inconsistent pixel count or end flags")

    `BFSD_ASSERT_NEXT(a_held_item_reaches_output, clk, rst_n,
        held_valid && out_space,
        out_valid,
        "decoded item did not reach the result register")

endmodule

// ===== design/bfsd_in_stage.sv =====
// Input register of the decoder: holds one accepted item until the core takes it.
module bfsd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfsd_pkg::in_item_t  item,
    input  logic                pop,
    output logic                held_valid,
    output bfsd_pkg::in_item_t  held_item
);

    logic               valid_reg;
    bfsd_pkg::in_item_t item_reg;

    // A new item may enter when the register is empty or the held one leaves in the same cycle.
    assign in_ready   = !valid_reg || pop;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

// ===== design/bfsd_core.sv =====
// Header parser, glyph position tracking and pixel masking of the decoder.
module bfsd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  bfsd_pkg::in_item_t  item,
    output bfsd_pkg::result_t   result
);

    logic [3:0]      hpos_reg,    hpos_next;
    logic [7:0]      width_reg,   width_next;
    logic [7:0]      height_reg,  height_next;
    logic [15:0]     count_reg,   count_next;
    logic [12:0]     bytes_reg,   bytes_next;
    logic [3:0]      tail_reg,    tail_next;
    logic [12:0]     offset_reg,  offset_next;
    logic [15:0]     glyph_reg,   glyph_next;
    bfsd_pkg::err_t  error_reg,   error_next;
    logic            finished_reg, finished_next;

    logic [15:0]     cell_bits;
    logic [16:0]     bits_round;

    assign cell_bits  = {8'd0, width_reg} * {8'd0, height_reg};
    assign bits_round = {1'b0, cell_bits} + 17'd7;

    always_comb
    begin
        bfsd_pkg::err_t hdr_err;
        logic           gend;
        logic           fend;
        logic [3:0]     cnt;
        logic [7:0]     mask;

        hpos_next     = hpos_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        count_next    = count_reg;
        bytes_next    = bytes_reg;
        tail_next     = tail_reg;
        offset_next   = offset_reg;
        glyph_next    = glyph_reg;
        error_next    = error_reg;
        finished_next = finished_reg;
        hdr_err       = bfsd_pkg::ERR_NONE;
        gend          = ({1'b0, offset_reg} + 14'd1) >= {1'b0, bytes_reg};
        fend          = gend && (({1'b0, glyph_reg} + 17'd1) >= {1'b0, count_reg});
        cnt           = gend ? tail_reg : bfsd_pkg::FULL_COUNT;
        mask          = bfsd_pkg::FULL_MASK << (bfsd_pkg::FULL_COUNT - cnt);

        result              = '0;
        result.kind         = bfsd_pkg::KIND_HEADER;
        result.error_code   = bfsd_pkg::ERR_NONE;

        if (error_reg != bfsd_pkg::ERR_NONE)
        begin
            result.kind       = bfsd_pkg::KIND_ERROR;
            result.error_code = error_reg;
        end
        else if (finished_reg)
        begin
            result.kind = bfsd_pkg::KIND_IGNORED;
        end
        else if (hpos_reg < bfsd_pkg::POS_DATA)
        begin
            unique case (hpos_reg) inside
                [bfsd_pkg::POS_MAGIC0:bfsd_pkg::POS_VERSION2]:
                begin
                    if (item.data_byte != bfsd_pkg::hdr_char(hpos_reg[2:0]))
                    begin
                        if (hpos_reg < bfsd_pkg::POS_VERSION0)
                        begin
                            hdr_err = bfsd_pkg::ERR_MAGIC;
                        end
                        else
                        begin
                            hdr_err = bfsd_pkg::ERR_VERSION;
                        end
                    end
                end
                bfsd_pkg::POS_WIDTH:
                begin
                    width_next = item.data_byte;
                    if (item.data_byte == 8'd0)
                    begin
                        hdr_err = bfsd_pkg::ERR_ZERO_WIDTH;
                    end
                end
                bfsd_pkg::POS_HEIGHT:
                begin
                    height_next = item.data_byte;
                    if (item.data_byte == 8'd0)
                    begin
                        hdr_err = bfsd_pkg::ERR_ZERO_HEIGHT;
                    end
                end
                bfsd_pkg::POS_COUNT_HI:
                begin
                    count_next = {item.data_byte, 8'd0};
                end
                bfsd_pkg::POS_COUNT_LO:
                begin
                    count_next = {count_reg[15:8], item.data_byte};
                    if (count_next == 16'd0)
                    begin
                        hdr_err = bfsd_pkg::ERR_ZERO_COUNT;
                    end
                    else
                    begin
                        bytes_next  = bits_round[15:3];
                        // Width and height are nonzero here, so the last byte
                        // of a glyph always holds one to eight pixels.
                        tail_next   = (cell_bits[2:0] == 3'd0) ?
                                      bfsd_pkg::FULL_COUNT : {1'b0, cell_bits[2:0]};
                        offset_next = '0;
                        glyph_next  = '0;
                    end
                end
                default:
                begin
                    hdr_err = bfsd_pkg::ERR_NONE;
                end
            endcase

            if (hdr_err == bfsd_pkg::ERR_NONE)
            begin
                hpos_next = hpos_reg + 4'd1;
                if (item.is_last)
                begin
                    hdr_err = bfsd_pkg::ERR_TRUNCATED;
                end
            end

            if (hdr_err != bfsd_pkg::ERR_NONE)
            begin
                error_next        = hdr_err;
                result.kind       = bfsd_pkg::KIND_ERROR;
                result.error_code = hdr_err;
            end
        end
        else if (item.is_last && !fend)
        begin
            error_next        = bfsd_pkg::ERR_TRUNCATED;
            result.kind       = bfsd_pkg::KIND_ERROR;
            result.error_code = bfsd_pkg::ERR_TRUNCATED;
        end
        else
        begin
            result.kind         = bfsd_pkg::KIND_GLYPH;
            result.glyph_number = glyph_reg;
            result.byte_offset  = offset_reg;
            result.pixels       = item.data_byte & mask;
            result.pixel_count  = cnt;
            result.glyph_end    = gend;
            result.font_end     = fend;
            if (fend)
            begin
                finished_next = 1'b1;
            end
            else if (gend)
            begin
                offset_next = '0;
                glyph_next  = glyph_reg + 16'd1;
            end
            else
            begin
                offset_next = offset_reg + 13'd1;
            end
        end

        result.cell_width  = width_next;
        result.cell_height = height_next;
        result.glyph_total = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpos_reg     <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            count_reg    <= '0;
            bytes_reg    <= '0;
            tail_reg     <= '0;
            offset_reg   <= '0;
            glyph_reg    <= '0;
            error_reg    <= bfsd_pkg::ERR_NONE;
            finished_reg <= 1'b0;
        end
        else if (take)
        begin
            hpos_reg     <= hpos_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            count_reg    <= count_next;
            bytes_reg    <= bytes_next;
            tail_reg     <= tail_next;
            offset_reg   <= offset_next;
            glyph_reg    <= glyph_next;
            error_reg    <= error_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== design/bfsd_out_stage.sv =====
// Result register of the decoder: holds one result until the consumer takes it.
module bfsd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bfsd_pkg::result_t  result_in,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output bfsd_pkg::result_t  result_out
);

    logic              valid_reg;
    bfsd_pkg::result_t result_reg;

    assign space      = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            result_reg <= result_in;
        end
    end

endmodule
